/* hw/rtl/sgms_pkg.sv */
package sgms_pkg;

  // Phase codes as reported on the result channel
  typedef enum logic [3:0] {
    PH_SETTLE   = 4'd0,
    PH_CHECK    = 4'd1,
    PH_SETTLE2  = 4'd2,
    PH_HOMING   = 4'd3,
    PH_IDLE     = 4'd4,
    PH_RAMPUP   = 4'd5,
    PH_RAMPDOWN = 4'd6,
    PH_OPENING  = 4'd7,
    PH_HOLD     = 4'd8,
    PH_CLOSING  = 4'd9
  } phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_JOG_DUTY     = 3'd0,
    REG_ACCEL_TICKS  = 3'd1,
    REG_DECEL_TICKS  = 3'd2,
    REG_HOLD_TICKS   = 3'd3,
    REG_SETTLE_TICKS = 3'd4
  } reg_idx_t;

  localparam int DUTY_W  = 7;
  localparam int TICK_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [DUTY_W-1:0] DUTY_BASE = 7'd25;
  localparam logic [DUTY_W-1:0] DUTY_STEP = 7'd5;
  localparam logic [DUTY_W-1:0] DUTY_TOP  = 7'd50;
  localparam logic [DUTY_W-1:0] DUTY_FALL = 7'd40;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;

  localparam logic [DUTY_W-1:0] JOG_DUTY_RST     = 7'd25;
  localparam logic [TICK_W-1:0] ACCEL_TICKS_RST  = 16'd400;
  localparam logic [TICK_W-1:0] DECEL_TICKS_RST  = 16'd300;
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 16'd10000;
  localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 16'd1000;

  typedef struct packed {
    logic [DUTY_W-1:0] jog_duty;
    logic [TICK_W-1:0] accel_step_ticks;
    logic [TICK_W-1:0] decel_step_ticks;
    logic [TICK_W-1:0] hold_open_ticks;
    logic [TICK_W-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic              drive_open;
    logic              drive_close;
    logic [DUTY_W-1:0] duty_percent;
    logic              buzzer_on;
    phase_t            phase_code;
  } result_t;

endpackage

/* hw/rtl/sliding_gate_motor_sequencer_core.sv */
// Channel | Direction | Handshake          | Payload
// in      | slave     | in_tvalid/tready   | in_tdata: sensor levels of one tick
// out     | master    | out_tvalid/tready  | out_tdata: drive, duty, buzzer, phase
// cfg     | slave     | cfg_valid/ready    | cfg_index, cfg_data (register write)
//
// One tick is taken per cycle while in_tready is high; its result is registered.
// The phase update is a single registered pass through sgms_seq.
// in_tready stays high unless the output register holds an untaken result.
// rst_n is synchronous: phase goes to first settle, counters clear and the
// registers load their defaults. cfg_ready is always high.
module sliding_gate_motor_sequencer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // [0] indoor_pressed, [1] terminal_reached, [2] home_reached, [7:3] zero
  input  logic [sgms_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] drive_open, [1] drive_close, [8:2] duty_percent, [9] buzzer_on,
  // [13:10] phase_code, [15:14] zero
  output logic [sgms_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sgms_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    step_en;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign step_en   = in_tvalid && in_tready;

  sgms_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sgms_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (step_en),
    .indoor_pressed   (in_tdata[0]),
    .terminal_reached (in_tdata[1]),
    .home_reached     (in_tdata[2]),
    .cfg              (cfg),
    .result           (result)
  );

  // Hold the result until the downstream side takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (step_en) res_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.phase_code, res_r.buzzer_on, res_r.duty_percent,
                       res_r.drive_close, res_r.drive_open};

  // Never drive both directions
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.drive_open && res_r.drive_close))
    else $error("both drive directions enabled");

  // Buzzer only while homing
  a_buzz_homing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.buzzer_on) |-> (res_r.phase_code == PH_HOMING))
    else $error("buzzer outside homing");

  // Stopped motor reports zero duty
  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.drive_open && !res_r.drive_close)
      |-> (res_r.duty_percent == '0))
    else $error("nonzero duty while stopped");

  // A stalled result blocks the next tick
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !step_en)
    else $error("tick accepted over a stalled result");

endmodule

/* hw/rtl/sgms_cfg_regs.sv */
module sgms_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [sgms_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [sgms_pkg::CFG_DATA_W-1:0]    wr_data,
  output sgms_pkg::cfg_t                     cfg
);
  import sgms_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_JOG_DUTY:     cfg_nxt.jog_duty         = wr_data[DUTY_W-1:0];
        REG_ACCEL_TICKS:  cfg_nxt.accel_step_ticks = wr_data[TICK_W-1:0];
        REG_DECEL_TICKS:  cfg_nxt.decel_step_ticks = wr_data[TICK_W-1:0];
        REG_HOLD_TICKS:   cfg_nxt.hold_open_ticks  = wr_data[TICK_W-1:0];
        REG_SETTLE_TICKS: cfg_nxt.settle_ticks     = wr_data[TICK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jog_duty         <= JOG_DUTY_RST;
      cfg_r.accel_step_ticks <= ACCEL_TICKS_RST;
      cfg_r.decel_step_ticks <= DECEL_TICKS_RST;
      cfg_r.hold_open_ticks  <= HOLD_TICKS_RST;
      cfg_r.settle_ticks     <= SETTLE_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/sgms_seq.sv */
module sgms_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic               indoor_pressed,
  input  logic               terminal_reached,
  input  logic               home_reached,
  input  sgms_pkg::cfg_t     cfg,
  output sgms_pkg::result_t  result
);
  import sgms_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [DUTY_W-1:0] ramp_r, ramp_nxt;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] limit;
  logic              count_done;
  logic [DUTY_W:0]   ramp_up_sum;
  logic [DUTY_W-1:0] ramp_down_val;
  logic [DUTY_W-1:0] jog_sat;

  // Pick the tick limit of the current timed phase
  always_comb begin
    case (phase_r)
      PH_RAMPUP:   limit = cfg.accel_step_ticks;
      PH_RAMPDOWN: limit = cfg.decel_step_ticks;
      PH_HOLD:     limit = cfg.hold_open_ticks;
      default:     limit = cfg.settle_ticks;
    endcase
  end

  assign tick_inc      = tick_r + 1'b1;
  assign count_done    = (tick_inc >= limit);
  assign ramp_up_sum   = {1'b0, ramp_r} + {1'b0, DUTY_STEP};
  assign ramp_down_val = (ramp_r > DUTY_STEP) ? (ramp_r - DUTY_STEP) : '0;
  assign jog_sat       = (cfg.jog_duty > DUTY_MAX) ? DUTY_MAX : cfg.jog_duty;

  // Advance the phase by one tick
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    ramp_nxt  = ramp_r;
    case (phase_r)
      PH_SETTLE, PH_SETTLE2, PH_HOLD: begin
        tick_nxt = count_done ? '0 : tick_inc;
        if (count_done) begin
          case (phase_r)
            PH_SETTLE:  phase_nxt = PH_CHECK;
            PH_SETTLE2: phase_nxt = PH_HOMING;
            default:    phase_nxt = PH_CLOSING;
          endcase
        end
      end
      PH_CHECK: begin
        tick_nxt  = '0;
        phase_nxt = home_reached ? PH_IDLE : PH_SETTLE2;
      end
      PH_HOMING, PH_CLOSING: begin
        if (home_reached) phase_nxt = PH_IDLE;
      end
      PH_IDLE: begin
        if (indoor_pressed) begin
          phase_nxt = PH_RAMPUP;
          ramp_nxt  = DUTY_BASE;
          tick_nxt  = '0;
        end
      end
      PH_RAMPUP: begin
        tick_nxt = count_done ? '0 : tick_inc;
        if (count_done) begin
          if (ramp_up_sum >= {1'b0, DUTY_TOP}) begin
            ramp_nxt  = DUTY_FALL;
            phase_nxt = PH_RAMPDOWN;
          end else begin
            ramp_nxt = ramp_up_sum[DUTY_W-1:0];
          end
        end
      end
      PH_RAMPDOWN: begin
        tick_nxt = count_done ? '0 : tick_inc;
        if (count_done) begin
          if (ramp_down_val <= DUTY_BASE) begin
            ramp_nxt  = DUTY_BASE;
            phase_nxt = PH_OPENING;
          end else begin
            ramp_nxt = ramp_down_val;
          end
        end
      end
      PH_OPENING: begin
        if (terminal_reached) begin
          phase_nxt = PH_HOLD;
          tick_nxt  = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  // Drive outputs from the post-tick state
  always_comb begin
    result = '0;
    result.phase_code = phase_nxt;
    case (phase_nxt)
      PH_HOMING: begin
        result.drive_close  = 1'b1;
        result.duty_percent = jog_sat;
        result.buzzer_on    = 1'b1;
      end
      PH_RAMPUP, PH_RAMPDOWN, PH_OPENING: begin
        result.drive_open   = 1'b1;
        result.duty_percent = ramp_nxt;
      end
      PH_CLOSING: begin
        result.drive_close  = 1'b1;
        result.duty_percent = DUTY_BASE;
      end
      default: result.duty_percent = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTLE;
      tick_r  <= '0;
      ramp_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      ramp_r  <= ramp_nxt;
    end
  end

  // Ramp duty stays inside the ramp band while the gate is driven open
  a_ramp_band: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RAMPUP || phase_r == PH_RAMPDOWN || phase_r == PH_OPENING)
      |-> (ramp_r >= DUTY_BASE && ramp_r < DUTY_TOP))
    else $error("ramp duty out of band");

endmodule
